>>> sv/stack_bytecode_execute_unit_defines.svh
// Assertion macros for the checker file.
`ifndef STACK_BYTECODE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_BYTECODE_EXECUTE_UNIT_DEFINES_SVH
// implication in the same cycle
`define SBEU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// implication in the next cycle
`define SBEU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> sv/sbeu_pkg.sv
// Shared types, opcodes and constants of the stack bytecode execute unit.
package sbeu_pkg;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int LOCALS_DEF      = 16;
   localparam int FRAMES_DEF      = 16;

   localparam int MODE_W      = 5;
   localparam int DATA_W      = 32;
   localparam int KIND_W      = 3;
   localparam int ERR_W       = 3;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 8;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_TUSER_W = 8;

   localparam logic [MODE_W-1:0] OP_LOAD    = 5'd0;
   localparam logic [MODE_W-1:0] OP_CONST   = 5'd1;
   localparam logic [MODE_W-1:0] OP_STORE   = 5'd2;
   localparam logic [MODE_W-1:0] OP_ADD     = 5'd3;
   localparam logic [MODE_W-1:0] OP_SUB     = 5'd4;
   localparam logic [MODE_W-1:0] OP_MUL     = 5'd5;
   localparam logic [MODE_W-1:0] OP_DIV     = 5'd6;
   localparam logic [MODE_W-1:0] OP_LT      = 5'd7;
   localparam logic [MODE_W-1:0] OP_GT      = 5'd8;
   localparam logic [MODE_W-1:0] OP_EQ      = 5'd9;
   localparam logic [MODE_W-1:0] OP_AND     = 5'd10;
   localparam logic [MODE_W-1:0] OP_OR      = 5'd11;
   localparam logic [MODE_W-1:0] OP_NOT     = 5'd12;
   localparam logic [MODE_W-1:0] OP_GOTO    = 5'd13;
   localparam logic [MODE_W-1:0] OP_IFFALSE = 5'd14;
   localparam logic [MODE_W-1:0] OP_INVOKE  = 5'd15;
   localparam logic [MODE_W-1:0] OP_RETURN  = 5'd16;
   localparam logic [MODE_W-1:0] OP_PRINT   = 5'd17;
   localparam logic [MODE_W-1:0] OP_STOP    = 5'd18;

   localparam logic [KIND_W-1:0] KIND_CONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_JUMP = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CALL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RET  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STOP = 3'd4;

   localparam logic [ERR_W-1:0] ERR_OK    = 3'd0;
   localparam logic [ERR_W-1:0] ERR_UNDER = 3'd1;
   localparam logic [ERR_W-1:0] ERR_OVER  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_DIV   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_FRAME = 3'd4;
   localparam logic [ERR_W-1:0] ERR_SLOT  = 3'd5;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] operand;
      logic [1:0]        pops;
      logic              slot_bad;
   } item_type;

   typedef struct packed {
      logic              valid;
      item_type          item;
   } queue_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] target;
      logic              pvalid;
      logic [DATA_W-1:0] pvalue;
      logic [ERR_W-1:0]  err;
   } rsp_type;
endpackage

>>> sv/stack_bytecode_execute_unit.sv
// A request passes through queue pop, two stack reads and execute before its result is
// valid; a divide also runs through the bit-serial divider.
// The back end takes a new request only once the previous one has passed queue pop, two
// stack reads and execute; a stalled result holds the back end in execute or divide.
// Reset (synchronous, high): clears stack pointer, frame depth, halt flag, local valid
// bits, queue and result valid; stack and local memories keep their contents.
module stack_bytecode_execute_unit #(
   parameter int STACK_DEPTH      = sbeu_pkg::STACK_DEPTH_DEF,
   parameter int LOCALS_PER_FRAME = sbeu_pkg::LOCALS_DEF,
   parameter int MAX_FRAMES       = sbeu_pkg::FRAMES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sbeu_pkg::REQ_TDATA_W-1:0] req_tdata,  // operand[31:0]
   input  logic [sbeu_pkg::REQ_TUSER_W-1:0] req_tuser,  // mode[4:0], zeros above
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sbeu_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // target[31:0], print_value[63:32],
                                                        // error_code[66:64], zeros above
   output logic [sbeu_pkg::RSP_TUSER_W-1:0] rsp_tuser   // control_kind[2:0], print_valid[3]
);
   sbeu_pkg::queue_type q;
   logic                q_ready;
   sbeu_pkg::rsp_type   rsp;

   sbeu_front #(
      .LOCALS_PER_FRAME (LOCALS_PER_FRAME)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_out      (q),
      .q_ready    (q_ready)
   );

   sbeu_back #(
      .STACK_DEPTH      (STACK_DEPTH),
      .LOCALS_PER_FRAME (LOCALS_PER_FRAME),
      .MAX_FRAMES       (MAX_FRAMES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q),
      .q_ready   (q_ready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {5'd0, rsp.err, rsp.pvalue, rsp.target};
   assign rsp_tuser = {4'd0, rsp.pvalid, rsp.kind};
endmodule

>>> sv/sbeu_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module sbeu_front #(
   parameter int LOCALS_PER_FRAME = sbeu_pkg::LOCALS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [sbeu_pkg::REQ_TDATA_W-1:0]       req_tdata,
   input  logic [sbeu_pkg::REQ_TUSER_W-1:0]       req_tuser,
   output sbeu_pkg::queue_type                    q_out,
   input  logic                                   q_ready
);
   sbeu_pkg::item_type cls;
   sbeu_pkg::item_type mem_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         cnt_ff;
   logic               push, pop;

   always_comb begin
      cls.mode     = req_tuser[sbeu_pkg::MODE_W-1:0];
      cls.operand  = req_tdata[sbeu_pkg::DATA_W-1:0];
      cls.slot_bad = req_tdata[31] || (req_tdata[30:0] >= 31'(LOCALS_PER_FRAME));
      unique case (cls.mode)
         sbeu_pkg::OP_STORE, sbeu_pkg::OP_NOT, sbeu_pkg::OP_IFFALSE,
         sbeu_pkg::OP_PRINT: cls.pops = 2'd1;
         sbeu_pkg::OP_ADD, sbeu_pkg::OP_SUB, sbeu_pkg::OP_MUL, sbeu_pkg::OP_DIV,
         sbeu_pkg::OP_LT, sbeu_pkg::OP_GT, sbeu_pkg::OP_EQ, sbeu_pkg::OP_AND,
         sbeu_pkg::OP_OR: cls.pops = 2'd2;
         default: cls.pops = 2'd0;
      endcase
   end

   assign req_tready  = (cnt_ff != 2'd2);
   assign push        = req_tvalid && req_tready;
   assign q_out.valid = (cnt_ff != 2'd0);
   assign q_out.item  = mem_ff[rd_ptr_ff];
   assign pop         = q_out.valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

>>> sv/sbeu_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sbeu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] q_ff, r_ff, d_ff;
   logic        neg_ff, busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [32:0] diff;

   assign diff     = {r_ff, q_ff[31]} - {1'b0, d_ff};
   assign done     = done_ff;
   assign quotient = neg_ff ? (32'd0 - q_ff) : q_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend[31] ? (32'd0 - dividend) : dividend;
         d_ff   <= divisor[31] ? (32'd0 - divisor) : divisor;
         r_ff   <= 32'd0;
         neg_ff <= dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            r_ff <= diff[31:0];
            q_ff <= {q_ff[30:0], 1'b1};
         end else begin
            r_ff <= {r_ff[30:0], q_ff[31]};
            q_ff <= {q_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end
endmodule

>>> sv/sbeu_back.sv
// Back end: runs queued instructions against the data stack, locals and frame state.
module sbeu_back #(
   parameter int STACK_DEPTH      = sbeu_pkg::STACK_DEPTH_DEF,
   parameter int LOCALS_PER_FRAME = sbeu_pkg::LOCALS_DEF,
   parameter int MAX_FRAMES       = sbeu_pkg::FRAMES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  sbeu_pkg::queue_type q_in,
   output logic                q_ready,
   output logic                out_valid,
   output sbeu_pkg::rsp_type   out_data,
   input  logic                out_ready
);
   localparam int NUM_LOCALS = MAX_FRAMES * LOCALS_PER_FRAME;
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int FDW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int SLW = (LOCALS_PER_FRAME > 1) ? $clog2(LOCALS_PER_FRAME) : 1;
   localparam int LW  = (NUM_LOCALS > 1) ? $clog2(NUM_LOCALS) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RA   = 3'd1;
   localparam logic [2:0] S_RB   = 3'd2;
   localparam logic [2:0] S_EX   = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [SPW-1:0]      sp_ff, sp_in, sp_m1, sp_m2;
   logic [FDW-1:0]      fd_ff, fd_in;
   logic                halted_ff, halted_in;
   logic [NUM_LOCALS-1:0] lw_ff;
   sbeu_pkg::item_type  item_ff;
   logic [31:0]         a_ff, b;
   logic [31:0]         stk_mem [STACK_DEPTH];
   logic [31:0]         stk_rd_ff;
   logic [31:0]         loc_mem [NUM_LOCALS];
   logic [31:0]         loc_rd_ff;
   logic                out_valid_ff;
   sbeu_pkg::rsp_type   out_ff, res;

   logic [AW-1:0]       rd_addr, wr_addr;
   logic                wr_en, loc_we, lw_clr, go_div, commit, out_free, div_done;
   logic [31:0]         wr_data, r, quotient;
   logic [LW-1:0]       loc_idx;
   logic [FDW:0]        fd_p1;

   assign sp_m1    = sp_ff - SPW'(1);
   assign sp_m2    = sp_ff - SPW'(2);
   assign rd_addr  = (state_ff == S_RA) ? sp_m1[AW-1:0] : sp_m2[AW-1:0];
   assign loc_idx  = LW'(fd_ff) * LW'(LOCALS_PER_FRAME) + LW'(item_ff.operand[SLW-1:0]);
   assign b        = stk_rd_ff;
   assign fd_p1    = {1'b0, fd_ff} + (FDW+1)'(1);
   assign out_free = !out_valid_ff || out_ready;
   assign q_ready  = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   sbeu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go_div),
      .dividend (b),
      .divisor  (a_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      unique case (item_ff.mode)
         sbeu_pkg::OP_ADD: r = b + a_ff;
         sbeu_pkg::OP_SUB: r = b - a_ff;
         sbeu_pkg::OP_MUL: r = b * a_ff;
         sbeu_pkg::OP_LT:  r = {31'd0, $signed(b) < $signed(a_ff)};
         sbeu_pkg::OP_GT:  r = {31'd0, $signed(b) > $signed(a_ff)};
         sbeu_pkg::OP_EQ:  r = {31'd0, b == a_ff};
         sbeu_pkg::OP_AND: r = {31'd0, (b != 32'd0) && (a_ff != 32'd0)};
         sbeu_pkg::OP_OR:  r = {31'd0, (b != 32'd0) || (a_ff != 32'd0)};
         default:          r = 32'd0;
      endcase
   end

   always_comb begin
      res       = '0;
      wr_en     = 1'b0;
      wr_addr   = sp_m2[AW-1:0];
      wr_data   = r;
      loc_we    = 1'b0;
      lw_clr    = 1'b0;
      go_div    = 1'b0;
      sp_in     = sp_ff;
      fd_in     = fd_ff;
      halted_in = halted_ff;
      commit    = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         S_IDLE: if (q_in.valid) state_in = S_RA;
         S_RA:   state_in = S_RB;
         S_RB:   state_in = S_EX;
         S_EX: begin
            if (halted_ff) begin
               res.kind = sbeu_pkg::KIND_STOP;
            end else if (sp_ff < SPW'(item_ff.pops)) begin
               res.err = sbeu_pkg::ERR_UNDER;
            end else begin
               unique case (item_ff.mode)
                  sbeu_pkg::OP_LOAD, sbeu_pkg::OP_CONST: begin
                     priority if (item_ff.mode == sbeu_pkg::OP_LOAD && item_ff.slot_bad) begin
                        res.err = sbeu_pkg::ERR_SLOT;
                     end else if (sp_ff >= SPW'(STACK_DEPTH)) begin
                        res.err = sbeu_pkg::ERR_OVER;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = sp_ff[AW-1:0];
                        wr_data = (item_ff.mode == sbeu_pkg::OP_CONST) ? item_ff.operand :
                                  (lw_ff[loc_idx] ? loc_rd_ff : 32'd0);
                        sp_in   = sp_ff + SPW'(1);
                     end
                  end
                  sbeu_pkg::OP_STORE: begin
                     if (item_ff.slot_bad) begin
                        res.err = sbeu_pkg::ERR_SLOT;
                     end else begin
                        loc_we = 1'b1;
                        sp_in  = sp_m1;
                     end
                  end
                  sbeu_pkg::OP_ADD, sbeu_pkg::OP_SUB, sbeu_pkg::OP_MUL, sbeu_pkg::OP_LT,
                  sbeu_pkg::OP_GT, sbeu_pkg::OP_EQ, sbeu_pkg::OP_AND, sbeu_pkg::OP_OR: begin
                     wr_en = 1'b1;
                     sp_in = sp_m1;
                  end
                  sbeu_pkg::OP_DIV: begin
                     if (a_ff == 32'd0 || (b == 32'h8000_0000 && a_ff == 32'hFFFF_FFFF)) begin
                        res.err = sbeu_pkg::ERR_DIV;
                     end else begin
                        go_div = 1'b1;
                     end
                  end
                  sbeu_pkg::OP_NOT: begin
                     wr_en   = 1'b1;
                     wr_addr = sp_m1[AW-1:0];
                     wr_data = {31'd0, a_ff == 32'd0};
                  end
                  sbeu_pkg::OP_GOTO: begin
                     res.kind   = sbeu_pkg::KIND_JUMP;
                     res.target = item_ff.operand;
                  end
                  sbeu_pkg::OP_IFFALSE: begin
                     sp_in = sp_m1;
                     if (a_ff == 32'd0) begin
                        res.kind   = sbeu_pkg::KIND_JUMP;
                        res.target = item_ff.operand;
                     end
                  end
                  sbeu_pkg::OP_INVOKE: begin
                     if (fd_p1 >= (FDW+1)'(MAX_FRAMES)) begin
                        res.err = sbeu_pkg::ERR_FRAME;
                     end else begin
                        fd_in      = fd_p1[FDW-1:0];
                        lw_clr     = 1'b1;
                        res.kind   = sbeu_pkg::KIND_CALL;
                        res.target = item_ff.operand;
                     end
                  end
                  sbeu_pkg::OP_RETURN: begin
                     if (fd_ff == '0) begin
                        res.err = sbeu_pkg::ERR_FRAME;
                     end else begin
                        fd_in    = fd_ff - FDW'(1);
                        res.kind = sbeu_pkg::KIND_RET;
                     end
                  end
                  sbeu_pkg::OP_PRINT: begin
                     sp_in      = sp_m1;
                     res.pvalid = 1'b1;
                     res.pvalue = a_ff;
                  end
                  sbeu_pkg::OP_STOP: begin
                     halted_in = 1'b1;
                     res.kind  = sbeu_pkg::KIND_STOP;
                  end
                  default: ;
               endcase
            end
            if (go_div) begin
               state_in = S_DIV;
            end else if (out_free) begin
               commit   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            wr_en   = 1'b1;
            wr_data = quotient;
            sp_in   = sp_m1;
            if (div_done && out_free) begin
               commit   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      stk_rd_ff <= stk_mem[rd_addr];
      if (wr_en && commit) begin
         stk_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      loc_rd_ff <= loc_mem[loc_idx];
      if (loc_we && commit) begin
         loc_mem[loc_idx] <= a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && q_in.valid) item_ff <= q_in.item;
      if (state_ff == S_RB) a_ff <= stk_rd_ff;
      if (commit) out_ff <= res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         fd_ff        <= '0;
         halted_ff    <= 1'b0;
         lw_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            sp_ff     <= sp_in;
            fd_ff     <= fd_in;
            halted_ff <= halted_in;
            if (loc_we) lw_ff[loc_idx] <= 1'b1;
            for (int i = 0; i < NUM_LOCALS; i++) begin
               if (lw_clr && (i / LOCALS_PER_FRAME) == int'(fd_in)) lw_ff[i] <= 1'b0;
            end
         end
         if (commit) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
      end
   end
endmodule

>>> sv/sbeu_checker.sv
// Port-level checker for the stack bytecode execute unit, bound to the top level.
`include "stack_bytecode_execute_unit_defines.svh"
module sbeu_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [sbeu_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [sbeu_pkg::REQ_TUSER_W-1:0] req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sbeu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [sbeu_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   `SBEU_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")
   `SBEU_ASSERT_NOW(a_err_quiet, rsp_tvalid && rsp_tdata[66:64] != sbeu_pkg::ERR_OK, rsp_tuser[2:0] == sbeu_pkg::KIND_CONT && rsp_tdata[31:0] == 32'd0 && !rsp_tuser[3], "faulted response carries control")
   `SBEU_ASSERT_NOW(a_print_ok, rsp_tvalid && rsp_tuser[3], rsp_tdata[66:64] == sbeu_pkg::ERR_OK && rsp_tuser[2:0] == sbeu_pkg::KIND_CONT, "print with fault or control")
   `SBEU_ASSERT_NOW(a_stop_only, rsp_tvalid && rsp_tuser[2:0] == sbeu_pkg::KIND_STOP, rsp_tdata[31:0] == 32'd0 && rsp_tdata[66:64] == sbeu_pkg::ERR_OK, "stop with target or fault")
endmodule

bind stack_bytecode_execute_unit sbeu_checker u_checker (.*);
